// ===== rtl/pms_pkg.sv =====
// Shared types, constants, helper functions and the microcode table of the particle block.
package pms_pkg;

  // Field widths of the stream payload and the state.
  localparam int POS_W   = 24;
  localparam int FORCE_W = 20;
  localparam int EXT_W   = 28;
  localparam int CFG_W   = 17;

  // Saturation limits of a 24-bit signed Q.8 value.
  localparam logic signed [EXT_W-1:0] POS_MAX = 28'sd8388607;
  localparam logic signed [EXT_W-1:0] POS_MIN = -28'sd8388608;

  // Fixed Q0.16 factors: 0.03 for easing, 0.3 for a bounce.
  localparam logic [23:0] EASE_Q16   = 24'd1966;
  localparam logic [23:0] BOUNCE_Q16 = 24'd19661;

  // Register reset values.
  localparam logic [16:0] FRICTION_RST    = 17'd62259;
  localparam logic [15:0] SPEED_LIMIT_RST = 16'd12800;
  localparam logic [7:0]  RADIUS_RST      = 8'd4;

  // Square root produces one result bit per step, the divider one quotient bit.
  localparam logic [4:0] SQRT_STEPS = 5'd24;
  localparam logic [4:0] DIV_STEPS  = 5'd16;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_FRICTION    = 3'd0,
    CFG_SPEED_LIMIT = 3'd1,
    CFG_RADIUS      = 3'd2,
    CFG_TARGET_X    = 3'd3,
    CFG_TARGET_Y    = 3'd4,
    CFG_START_X     = 3'd5,
    CFG_START_Y     = 3'd6
  } cfg_idx_t;

  // Input modes.
  typedef enum logic [1:0] {
    MODE_PHYSICS = 2'd0,
    MODE_EASE    = 2'd1,
    MODE_BOUND   = 2'd2,
    MODE_PLACE   = 2'd3
  } mode_t;

  typedef struct packed {
    logic [16:0] friction;
    logic [15:0] speed_limit;
    logic [7:0]  radius;
    logic [11:0] target_x;
    logic [11:0] target_y;
    logic [11:0] start_x;
    logic [11:0] start_y;
  } cfg_t;

  // Datapath operations, one per control word.
  typedef enum logic [4:0] {
    OP_NOP       = 5'd0,
    OP_ADD_FORCE = 5'd1,
    OP_SQ_X      = 5'd2,
    OP_SQ_Y      = 5'd3,
    OP_SQ_LIM    = 5'd4,
    OP_SQRT      = 5'd5,
    OP_MUL_LX    = 5'd6,
    OP_DIV       = 5'd7,
    OP_SET_VX    = 5'd8,
    OP_SET_VY    = 5'd9,
    OP_MOVE      = 5'd10,
    OP_FRIC_X    = 5'd11,
    OP_DAMP_X    = 5'd12,
    OP_DAMP_Y    = 5'd13,
    OP_EASE_X    = 5'd14,
    OP_STEP_X    = 5'd15,
    OP_STEP_Y    = 5'd16,
    OP_CLAMP     = 5'd17,
    OP_BOUNCE_X  = 5'd18,
    OP_BOUNCE_Y  = 5'd19,
    OP_PLACE     = 5'd20,
    OP_EMIT      = 5'd21
  } op_t;

  // Next-step selection of a control word.
  typedef enum logic [2:0] {
    COND_NEXT     = 3'd0,
    COND_JUMP     = 3'd1,
    COND_NO_START = 3'd2,
    COND_MODE     = 3'd3,
    COND_BUSY     = 3'd4,
    COND_LE_LIMIT = 3'd5,
    COND_WAIT_OUT = 3'd6
  } cond_t;

  typedef logic [4:0] pc_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } uword_t;

  // Status flags that steer the sequencer.
  typedef struct packed {
    logic busy;
    logic le_limit;
    logic out_full;
  } stat_t;

  // Commands to the iterative root and divide unit.
  typedef struct packed {
    logic start_sqrt;
    logic start_div;
  } iter_cmd_t;

  // Program labels.
  localparam pc_t L_IDLE      = 5'd0;
  localparam pc_t L_DISPATCH  = 5'd1;
  localparam pc_t L_TABLE     = 5'd2;
  localparam pc_t L_PHYS      = 5'd6;
  localparam pc_t L_WAIT_SQRT = 5'd12;
  localparam pc_t L_WAIT_DX   = 5'd15;
  localparam pc_t L_WAIT_DY   = 5'd18;
  localparam pc_t L_MOVE      = 5'd20;
  localparam pc_t L_EASE      = 5'd24;
  localparam pc_t L_BOUND     = 5'd27;
  localparam pc_t L_PLACE     = 5'd30;
  localparam pc_t L_EMIT      = 5'd31;

  function automatic uword_t uw(op_t op, cond_t cond, pc_t target);
    uword_t w;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  // The control program, one word per step.
  function automatic uword_t ucode(pc_t pc);
    uword_t w;
    case (pc)
      5'd0:  w = uw(OP_NOP,       COND_NO_START, L_IDLE);
      5'd1:  w = uw(OP_NOP,       COND_MODE,     L_TABLE);
      5'd2:  w = uw(OP_NOP,       COND_JUMP,     L_PHYS);
      5'd3:  w = uw(OP_NOP,       COND_JUMP,     L_EASE);
      5'd4:  w = uw(OP_NOP,       COND_JUMP,     L_BOUND);
      5'd5:  w = uw(OP_NOP,       COND_JUMP,     L_PLACE);
      5'd6:  w = uw(OP_ADD_FORCE, COND_NEXT,     L_IDLE);
      5'd7:  w = uw(OP_SQ_X,      COND_NEXT,     L_IDLE);
      5'd8:  w = uw(OP_SQ_Y,      COND_NEXT,     L_IDLE);
      5'd9:  w = uw(OP_SQ_LIM,    COND_NEXT,     L_IDLE);
      5'd10: w = uw(OP_NOP,       COND_LE_LIMIT, L_MOVE);
      5'd11: w = uw(OP_SQRT,      COND_NEXT,     L_IDLE);
      5'd12: w = uw(OP_NOP,       COND_BUSY,     L_WAIT_SQRT);
      5'd13: w = uw(OP_MUL_LX,    COND_NEXT,     L_IDLE);
      5'd14: w = uw(OP_DIV,       COND_NEXT,     L_IDLE);
      5'd15: w = uw(OP_NOP,       COND_BUSY,     L_WAIT_DX);
      5'd16: w = uw(OP_SET_VX,    COND_NEXT,     L_IDLE);
      5'd17: w = uw(OP_DIV,       COND_NEXT,     L_IDLE);
      5'd18: w = uw(OP_NOP,       COND_BUSY,     L_WAIT_DY);
      5'd19: w = uw(OP_SET_VY,    COND_NEXT,     L_IDLE);
      5'd20: w = uw(OP_MOVE,      COND_NEXT,     L_IDLE);
      5'd21: w = uw(OP_FRIC_X,    COND_NEXT,     L_IDLE);
      5'd22: w = uw(OP_DAMP_X,    COND_NEXT,     L_IDLE);
      5'd23: w = uw(OP_DAMP_Y,    COND_JUMP,     L_EMIT);
      5'd24: w = uw(OP_EASE_X,    COND_NEXT,     L_IDLE);
      5'd25: w = uw(OP_STEP_X,    COND_NEXT,     L_IDLE);
      5'd26: w = uw(OP_STEP_Y,    COND_JUMP,     L_EMIT);
      5'd27: w = uw(OP_CLAMP,     COND_NEXT,     L_IDLE);
      5'd28: w = uw(OP_BOUNCE_X,  COND_NEXT,     L_IDLE);
      5'd29: w = uw(OP_BOUNCE_Y,  COND_JUMP,     L_EMIT);
      5'd30: w = uw(OP_PLACE,     COND_JUMP,     L_EMIT);
      5'd31: w = uw(OP_EMIT,      COND_WAIT_OUT, L_IDLE);
      default: w = uw(OP_NOP,     COND_JUMP,     L_IDLE);
    endcase
    return w;
  endfunction

  // Clamp a wide signed value into 24 bits.
  function automatic logic signed [POS_W-1:0] sat24(logic signed [EXT_W-1:0] v);
    logic signed [POS_W-1:0] r;
    if (v > POS_MAX) begin
      r = POS_MAX[POS_W-1:0];
    end else if (v < POS_MIN) begin
      r = POS_MIN[POS_W-1:0];
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

  // Sign-extend a 24-bit value to the working width.
  function automatic logic signed [EXT_W-1:0] sx(logic signed [POS_W-1:0] v);
    return $signed({{(EXT_W-POS_W){v[POS_W-1]}}, v});
  endfunction

  // Magnitude of a 24-bit signed value; the most negative value maps to 2^23.
  function automatic logic [POS_W-1:0] abs24(logic signed [POS_W-1:0] v);
    return v[POS_W-1] ? (~v + 24'd1) : v;
  endfunction

  // Q0.16 product rounded to nearest, ties away from zero on the magnitude.
  function automatic logic [25:0] rnd_q16(logic [47:0] p);
    logic [41:0] s;
    s = {1'b0, p[40:0]} + 42'd32768;
    return s[41:16];
  endfunction

  // Give a magnitude its sign back.
  function automatic logic signed [EXT_W-1:0] with_sign(logic neg, logic [25:0] mag);
    logic signed [EXT_W-1:0] m;
    m = $signed({2'b00, mag});
    return neg ? -m : m;
  endfunction

endpackage

// ===== rtl/pms_seq.sv =====
// Microcode sequencer: step counter, control table lookup and jump selection.
module pms_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [1:0]      mode_in,
  input  pms_pkg::stat_t  stat,
  output pms_pkg::op_t    op,
  output logic            idle
);
  import pms_pkg::*;

  pc_t        pc;
  pc_t        pc_next;
  logic [1:0] mode;
  uword_t     word;

  // Current control word.
  assign word = ucode(pc);
  assign op   = word.op;
  assign idle = (pc == L_IDLE);

  // Next step: fall through, jump, dispatch on mode or hold.
  always_comb begin
    case (word.cond)
      COND_NEXT:     pc_next = pc + 5'd1;
      COND_JUMP:     pc_next = word.target;
      COND_NO_START: pc_next = start ? pc + 5'd1 : word.target;
      COND_MODE:     pc_next = word.target + pc_t'(mode);
      COND_BUSY:     pc_next = stat.busy ? word.target : pc + 5'd1;
      COND_LE_LIMIT: pc_next = stat.le_limit ? word.target : pc + 5'd1;
      COND_WAIT_OUT: pc_next = stat.out_full ? pc : word.target;
      default:       pc_next = L_IDLE;
    endcase
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= L_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  // Mode of the item being worked on.
  always_ff @(posedge clk) begin
    if (start) begin
      mode <= mode_in;
    end
  end

endmodule

// ===== rtl/pms_iter.sv =====
// Shared iterative unit: bit-pair integer square root and restoring divider.
module pms_iter (
  input  logic                clk,
  input  logic                rst,
  input  pms_pkg::iter_cmd_t  cmd,
  input  logic [47:0]         n_in,
  input  logic [39:0]         dvd_in,
  output logic                busy,
  output logic [15:0]         quot
);
  import pms_pkg::*;

  logic        is_sqrt;
  logic [4:0]  cnt;
  logic [47:0] sh;
  logic [25:0] rem;
  logic [23:0] root;

  logic [27:0] sq_rem_t;
  logic [27:0] sq_trial;
  logic        sq_ge;
  logic [27:0] sq_diff;
  logic [24:0] dv_rem_t;
  logic        dv_ge;
  logic [24:0] dv_diff;

  // One root bit per step: bring down two radicand bits and try 4*root+1.
  assign sq_rem_t = {rem, sh[47:46]};
  assign sq_trial = {2'b00, root, 2'b01};
  assign sq_ge    = (sq_rem_t >= sq_trial);
  assign sq_diff  = sq_rem_t - sq_trial;

  // One quotient bit per step against the root held from the square root.
  assign dv_rem_t = {rem[23:0], sh[15]};
  assign dv_ge    = (dv_rem_t >= {1'b0, root});
  assign dv_diff  = dv_rem_t - {1'b0, root};

  assign quot = sh[15:0];

  // Busy flag and step count.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (cmd.start_sqrt) begin
      busy <= 1'b1;
      cnt  <= SQRT_STEPS - 5'd1;
    end else if (cmd.start_div) begin
      busy <= 1'b1;
      cnt  <= DIV_STEPS - 5'd1;
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end
      cnt <= cnt - 5'd1;
    end
  end

  // Working registers; the quotient collects in the low bits of the shifter.
  always_ff @(posedge clk) begin
    if (cmd.start_sqrt) begin
      is_sqrt <= 1'b1;
      sh      <= n_in;
      rem     <= '0;
      root    <= '0;
    end else if (cmd.start_div) begin
      is_sqrt <= 1'b0;
      sh      <= {32'd0, dvd_in[15:0]};
      rem     <= {2'b00, dvd_in[39:16]};
    end else if (busy) begin
      if (is_sqrt) begin
        rem  <= sq_ge ? sq_diff[25:0] : sq_rem_t[25:0];
        root <= {root[22:0], sq_ge};
        sh   <= {sh[45:0], 2'b00};
      end else begin
        rem       <= {2'b00, dv_ge ? dv_diff[23:0] : dv_rem_t[23:0]};
        sh[15:0]  <= {sh[14:0], dv_ge};
      end
    end
  end

endmodule

// ===== rtl/pms_dpath.sv =====
// Datapath: particle state, shared multiplier, saturating adders and the clamp logic.
module pms_dpath #(
  parameter int WINDOW_WIDTH  = 1024,
  parameter int WINDOW_HEIGHT = 768
) (
  input  logic                       clk,
  input  logic                       rst,
  input  pms_pkg::op_t               op,
  input  pms_pkg::cfg_t              cfg,
  input  logic                       start,
  input  logic signed [19:0]         force_x,
  input  logic signed [19:0]         force_y,
  input  logic                       iter_busy,
  input  logic [15:0]                quot,
  output pms_pkg::iter_cmd_t         iter_cmd,
  output logic [47:0]                iter_n,
  output logic [39:0]                iter_dvd,
  output logic                       le_limit,
  output logic signed [23:0]         pos_x,
  output logic signed [23:0]         pos_y,
  output logic signed [23:0]         vel_x,
  output logic signed [23:0]         vel_y
);
  import pms_pkg::*;

  localparam logic signed [25:0] WIN_W = 26'(WINDOW_WIDTH * 256);
  localparam logic signed [25:0] WIN_H = 26'(WINDOW_HEIGHT * 256);

  logic signed [19:0] fx;
  logic signed [19:0] fy;
  logic [47:0]        prod;
  logic [47:0]        acc;
  logic               hit_x;
  logic               hit_y;

  logic [23:0]        ax;
  logic [23:0]        ay;
  logic signed [24:0] dx;
  logic signed [24:0] dy;
  logic [23:0]        adx;
  logic [23:0]        ady;
  logic [23:0]        mul_a;
  logic [23:0]        mul_b;
  logic               mul_en;
  logic [47:0]        product;
  logic [25:0]        rnd;
  logic [23:0]        lim24;
  logic [23:0]        fric24;

  logic signed [25:0] px26;
  logic signed [25:0] py26;
  logic signed [25:0] r26;
  logic               hi_x;
  logic               lo_x;
  logic               hi_y;
  logic               lo_y;
  logic signed [25:0] edge_x;
  logic signed [25:0] edge_y;

  // Magnitudes and ease distances.
  assign ax     = abs24(vel_x);
  assign ay     = abs24(vel_y);
  assign dx     = $signed({5'd0, cfg.target_x, 8'd0}) - $signed({pos_x[23], pos_x});
  assign dy     = $signed({5'd0, cfg.target_y, 8'd0}) - $signed({pos_y[23], pos_y});
  assign adx    = dx[24] ? 24'(-dx) : dx[23:0];
  assign ady    = dy[24] ? 24'(-dy) : dy[23:0];
  assign lim24  = {8'd0, cfg.speed_limit};
  assign fric24 = {7'd0, cfg.friction};
  assign rnd    = rnd_q16(prod);

  // Multiplier operand selection.
  always_comb begin
    mul_en = 1'b1;
    case (op)
      OP_SQ_X:     begin mul_a = ax;    mul_b = ax;         end
      OP_SQ_Y:     begin mul_a = ay;    mul_b = ay;         end
      OP_SQ_LIM:   begin mul_a = lim24; mul_b = lim24;      end
      OP_MUL_LX:   begin mul_a = ax;    mul_b = lim24;      end
      OP_SET_VX:   begin mul_a = ay;    mul_b = lim24;      end
      OP_FRIC_X:   begin mul_a = ax;    mul_b = fric24;     end
      OP_DAMP_X:   begin mul_a = ay;    mul_b = fric24;     end
      OP_EASE_X:   begin mul_a = adx;   mul_b = EASE_Q16;   end
      OP_STEP_X:   begin mul_a = ady;   mul_b = EASE_Q16;   end
      OP_CLAMP:    begin mul_a = ax;    mul_b = BOUNCE_Q16; end
      OP_BOUNCE_X: begin mul_a = ay;    mul_b = BOUNCE_Q16; end
      default: begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
      end
    endcase
  end

  assign product = mul_a * mul_b;

  // Speed test and commands to the iterative unit.
  assign le_limit            = (acc <= prod);
  assign iter_cmd.start_sqrt = (op == OP_SQRT) && !iter_busy;
  assign iter_cmd.start_div  = (op == OP_DIV) && !iter_busy;
  assign iter_n              = acc;
  assign iter_dvd            = prod[39:0];

  // Window tests against the radius.
  assign px26   = $signed({{2{pos_x[23]}}, pos_x});
  assign py26   = $signed({{2{pos_y[23]}}, pos_y});
  assign r26    = $signed({10'd0, cfg.radius, 8'd0});
  assign hi_x   = (px26 + r26) > WIN_W;
  assign lo_x   = (px26 - r26) < 26'sd0;
  assign hi_y   = (py26 + r26) > WIN_H;
  assign lo_y   = (py26 - r26) < 26'sd0;
  assign edge_x = WIN_W - r26;
  assign edge_y = WIN_H - r26;

  // Captured forces, product and sum registers.
  always_ff @(posedge clk) begin
    if (start) begin
      fx <= force_x;
      fy <= force_y;
    end
    if (mul_en) begin
      prod <= product;
    end
    if (op == OP_SQ_Y) begin
      acc <= prod;
    end else if (op == OP_SQ_LIM) begin
      acc <= acc + prod;
    end
    if (op == OP_CLAMP) begin
      hit_x <= hi_x || lo_x;
      hit_y <= hi_y || lo_y;
    end
  end

  // Particle state updated by the current operation.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0;
      pos_y <= '0;
      vel_x <= '0;
      vel_y <= '0;
    end else begin
      case (op)
        OP_ADD_FORCE: begin
          vel_x <= sat24(sx(vel_x) + $signed({{8{fx[19]}}, fx}));
          vel_y <= sat24(sx(vel_y) + $signed({{8{fy[19]}}, fy}));
        end
        OP_SET_VX: vel_x <= vel_x[23] ? -$signed({8'd0, quot}) : $signed({8'd0, quot});
        OP_SET_VY: vel_y <= vel_y[23] ? -$signed({8'd0, quot}) : $signed({8'd0, quot});
        OP_MOVE: begin
          pos_x <= sat24(sx(pos_x) + sx(vel_x));
          pos_y <= sat24(sx(pos_y) + sx(vel_y));
        end
        OP_DAMP_X: vel_x <= sat24(with_sign(vel_x[23], rnd));
        OP_DAMP_Y: vel_y <= sat24(with_sign(vel_y[23], rnd));
        OP_STEP_X: pos_x <= sat24(sx(pos_x) + with_sign(dx[24], rnd));
        OP_STEP_Y: pos_y <= sat24(sx(pos_y) + with_sign(dy[24], rnd));
        OP_CLAMP: begin
          // The right edge wins on x, the low edge wins on y.
          if (hi_x) begin
            pos_x <= edge_x[23:0];
          end else if (lo_x) begin
            pos_x <= r26[23:0];
          end
          if (lo_y) begin
            pos_y <= r26[23:0];
          end else if (hi_y) begin
            pos_y <= edge_y[23:0];
          end
        end
        OP_BOUNCE_X: begin
          if (hit_x) begin
            vel_x <= sat24(with_sign(!vel_x[23], rnd));
          end
        end
        OP_BOUNCE_Y: begin
          if (hit_y) begin
            vel_y <= sat24(with_sign(!vel_y[23], rnd));
          end
        end
        OP_PLACE: begin
          pos_x <= $signed({4'd0, cfg.start_x, 8'd0});
          pos_y <= $signed({4'd0, cfg.start_y, 8'd0});
          vel_x <= '0;
          vel_y <= '0;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/particle_motion_step.sv =====
// Top level of the particle motion block: registers, sequencer, datapath and result register.
// A physics tick that hits the speed limit also runs the 24-step square root and two
// 16-step divisions of the shared iterative unit. One item is worked at a time; a finished
// result waits in the output register while the next item is taken.
// Synchronous reset clears the particle state, the registers to their defaults and the output.
module particle_motion_step #(
  parameter int WINDOW_WIDTH  = 1024,
  parameter int WINDOW_HEIGHT = 768
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // force_x [19:0], force_y [39:20]
  input  logic [1:0]  s_axis_tuser,   // mode [1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // pos_x [23:0], pos_y [47:24], vel_x [71:48], vel_y [95:72]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data
);
  import pms_pkg::*;

  cfg_t               cfg;
  op_t                op;
  stat_t              stat;
  iter_cmd_t          iter_cmd;
  logic               idle;
  logic               start;
  logic               out_full;
  logic               iter_busy;
  logic [15:0]        quot;
  logic [47:0]        iter_n;
  logic [39:0]        iter_dvd;
  logic               le_limit;
  logic signed [23:0] pos_x;
  logic signed [23:0] pos_y;
  logic signed [23:0] vel_x;
  logic signed [23:0] vel_y;

  // Input transfer and output occupancy.
  assign s_axis_tready = idle;
  assign start         = s_axis_tvalid && idle;
  assign out_full      = m_axis_tvalid && !m_axis_tready;

  assign stat.busy     = iter_busy;
  assign stat.le_limit = le_limit;
  assign stat.out_full = out_full;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.friction    <= FRICTION_RST;
      cfg.speed_limit <= SPEED_LIMIT_RST;
      cfg.radius      <= RADIUS_RST;
      cfg.target_x    <= '0;
      cfg.target_y    <= '0;
      cfg.start_x     <= '0;
      cfg.start_y     <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FRICTION:    cfg.friction    <= cfg_data;
        CFG_SPEED_LIMIT: cfg.speed_limit <= cfg_data[15:0];
        CFG_RADIUS:      cfg.radius      <= cfg_data[7:0];
        CFG_TARGET_X:    cfg.target_x    <= cfg_data[11:0];
        CFG_TARGET_Y:    cfg.target_y    <= cfg_data[11:0];
        CFG_START_X:     cfg.start_x     <= cfg_data[11:0];
        CFG_START_Y:     cfg.start_y     <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  pms_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .mode_in (s_axis_tuser),
    .stat    (stat),
    .op      (op),
    .idle    (idle)
  );

  pms_iter u_iter (
    .clk    (clk),
    .rst    (rst),
    .cmd    (iter_cmd),
    .n_in   (iter_n),
    .dvd_in (iter_dvd),
    .busy   (iter_busy),
    .quot   (quot)
  );

  pms_dpath #(
    .WINDOW_WIDTH  (WINDOW_WIDTH),
    .WINDOW_HEIGHT (WINDOW_HEIGHT)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .cfg       (cfg),
    .start     (start),
    .force_x   (s_axis_tdata[19:0]),
    .force_y   (s_axis_tdata[39:20]),
    .iter_busy (iter_busy),
    .quot      (quot),
    .iter_cmd  (iter_cmd),
    .iter_n    (iter_n),
    .iter_dvd  (iter_dvd),
    .le_limit  (le_limit),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .vel_x     (vel_x),
    .vel_y     (vel_y)
  );

  // Result register: loaded when the program emits and the slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((op == OP_EMIT) && !out_full) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((op == OP_EMIT) && !out_full) begin
      m_axis_tdata <= {vel_y, vel_x, pos_y, pos_x};
    end
  end

endmodule

// ===== rtl/pms_checker.sv =====
// Port-level checker for the particle motion block and its bind.
module pms_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata
);

  logic       in_xfer;
  logic       out_xfer;
  logic [1:0] pending;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  // Items taken but not yet delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_xfer && !out_xfer) begin
      pending <= pending + 2'd1;
    end else if (out_xfer && !in_xfer) begin
      pending <= pending - 2'd1;
    end
  end

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // A stalled result stays and holds its data.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // One item at a time: input closes right after a transfer.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !s_axis_tready)
    else $error("input open right after a transfer");

  // Every delivered result belongs to an accepted item.
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    out_xfer |-> pending != 2'd0)
    else $error("result without an item");

  // At most one item in work and one result waiting.
  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending == 2'd2 |-> !s_axis_tready)
    else $error("too many items outstanding");

endmodule

bind particle_motion_step pms_checker u_pms_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
